FILE: rtl/ppw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppw_pkg
// shared types and codes of the path point warp block
// ----------------------------------------------------------------------------
package ppw_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  localparam int PTS_W  = 9;
  localparam int PT_W   = 96;
  localparam int ROOT_W = 33;
  localparam int RAD_W  = 66;
  localparam int FRAC_W = 30;
  localparam int NUM_W  = 34;

  typedef struct packed {
    logic               operation;
    logic        [7:0]  point_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] glyph_x;
    logic signed [31:0] glyph_y;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               off_path;
  } out_t;

endpackage

FILE: rtl/ppw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppw_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module ppw_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ppw_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppw_sqrt
// digit-by-digit integer square root, one bit pair per cycle
// ----------------------------------------------------------------------------
module ppw_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppw_pkg::RAD_W-1:0]     radicand,
  output logic                          done,
  output logic [ppw_pkg::ROOT_W-1:0]    root
);

  localparam int STEPS = ppw_pkg::RAD_W / 2;

  logic [ppw_pkg::RAD_W-1:0] val;
  logic [36:0]               rem;
  logic [33:0]               rt;
  logic [5:0]                cnt;
  logic                      busy;
  logic [36:0]               rem_s;
  logic [36:0]               trial;

  assign rem_s = {rem[34:0], val[ppw_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, rt, 2'b01};
  assign root  = rt[ppw_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(STEPS);
        val  <= radicand;
        rem  <= '0;
        rt   <= '0;
      end else if (busy) begin
        val <= val << 2;
        if (rem_s >= trial) begin
          rem <= rem_s - trial;
          rt  <= {rt[32:0], 1'b1};
        end else begin
          rem <= rem_s;
          rt  <= {rt[32:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("sqrt done while busy");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("sqrt did not start");
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt != 6'd0)
    else $error("sqrt count underflow");

endmodule

FILE: rtl/ppw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppw_div
// restoring divider for the segment fraction, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ppw_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ppw_pkg::NUM_W-1:0]   num,
  input  logic [ppw_pkg::ROOT_W-1:0]  den,
  output logic                        done,
  output logic [ppw_pkg::FRAC_W-1:0]  quot
);

  logic [34:0]                r;
  logic [ppw_pkg::ROOT_W-1:0] d;
  logic [4:0]                 cnt;
  logic                       busy;
  logic [35:0]                r2;

  assign r2 = {r, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(ppw_pkg::FRAC_W);
        r    <= 35'(num);
        d    <= den;
        quot <= '0;
      end else if (busy) begin
        if (r2 >= 36'(d)) begin
          r    <= 35'(r2 - 36'(d));
          quot <= {quot[ppw_pkg::FRAC_W-2:0], 1'b1};
        end else begin
          r    <= 35'(r2);
          quot <= {quot[ppw_pkg::FRAC_W-2:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt != 5'd0)
    else $error("divider count underflow");

endmodule

FILE: rtl/path_point_warp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_point_warp
// warps glyph points onto a stored 3d polyline by arc length
// ----------------------------------------------------------------------------
// input beats: a load beat writes one polyline point and side direction into
// the point rams and gives no result; a map beat walks the segments and gives
// one result beat (warped point, off_path flag).
// cfg_we/cfg_data write points_in_use; the user must write it only while the
// block is idle, since the block itself does not enforce that. a map beat
// walks each segment through the ram read (fetch and capture states), the
// squared-length multiplies and the square root, then does the fraction
// divide and the six final multiplies; the first fetch comes before the walk
// and the output register after it. up to 255 segments are walked; one beat
// is worked at a time. the square root unit works one bit pair per cycle.
// the result sits in an output register; the next input beat is taken while
// it waits, and a stalled result holds until out_stall drops.
// reset clears control state and sets points_in_use to 256; the rams are not
// cleared and a point must be loaded before a map beat reads it.
// ----------------------------------------------------------------------------
module path_point_warp #(
  parameter int MAX_POINTS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ppw_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ppw_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [ppw_pkg::PTS_W-1:0]       cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int LW = AW + 34;
  localparam int RW = 50;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_CAPT, ST_SQ, ST_ROOT, ST_DIV, ST_MUL, ST_FIN
  } state_t;

  state_t                         state;
  logic [ppw_pkg::PTS_W-1:0]      points_in_use;
  logic [NW-1:0]                  n_use;
  logic [AW-1:0]                  k;
  logic [2:0]                     j;
  logic signed [32:0]             px;
  logic signed [32:0]             py;
  logic [LW-1:0]                  lower;
  logic signed [31:0]             p0 [3];
  logic signed [31:0]             p1 [3];
  logic signed [32:0]             dv [3];
  logic [ppw_pkg::RAD_W-1:0]      acc;
  logic [ppw_pkg::RAD_W-1:0]      prod;
  logic                           mneg;
  logic [ppw_pkg::FRAC_W-1:0]     f;
  logic signed [RW-1:0]           res [3];
  logic                           off;

  logic                           accept;
  logic                           ram_we;
  logic [ppw_pkg::PT_W-1:0]       pos_q;
  logic [ppw_pkg::PT_W-1:0]       dir_q;
  logic signed [31:0]             pos_c [3];
  logic signed [31:0]             dir_c [3];
  logic [32:0]                    mul_a;
  logic [32:0]                    mul_b;
  logic                           mul_neg;
  logic                           sq_go;
  logic                           sq_done;
  logic [ppw_pkg::ROOT_W-1:0]     sq_root;
  logic [LW-1:0]                  upper;
  logic signed [LW:0]             px_e;
  logic                           hit;
  logic signed [LW:0]             diff;
  logic                           div_go;
  logic                           div_done;
  logic [ppw_pkg::FRAC_W-1:0]     div_q;
  logic [2:0]                     jm;
  logic [ppw_pkg::RAD_W-1:0]      shifted;
  logic signed [RW-1:0]           term;
  logic [1:0]                     axis;
  logic signed [31:0]             sat [3];

  assign n_use  = (32'(points_in_use) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(points_in_use);
  assign accept = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign ram_we = accept && (in_data.operation == ppw_pkg::OP_LOAD)
                  && (32'(in_data.point_index) < MAX_POINTS);

  ppw_ram #(.WIDTH(ppw_pkg::PT_W), .DEPTH(MAX_POINTS)) u_pos_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_data.point_index)),
    .wdata ({in_data.pos_x, in_data.pos_y, in_data.pos_z}),
    .raddr (k),
    .rdata (pos_q)
  );

  ppw_ram #(.WIDTH(ppw_pkg::PT_W), .DEPTH(MAX_POINTS)) u_dir_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_data.point_index)),
    .wdata ({in_data.dir_x, in_data.dir_y, in_data.dir_z}),
    .raddr (k - AW'(1)),
    .rdata (dir_q)
  );

  assign pos_c[0] = pos_q[95:64];
  assign pos_c[1] = pos_q[63:32];
  assign pos_c[2] = pos_q[31:0];
  assign dir_c[0] = dir_q[95:64];
  assign dir_c[1] = dir_q[63:32];
  assign dir_c[2] = dir_q[31:0];

  // shared multiplier operands, magnitudes only
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    axis    = '0;
    if (state == ST_SQ) begin
      case (j)
        3'd0: mul_a = dv[0][32] ? 33'(-dv[0]) : 33'(dv[0]);
        3'd1: mul_a = dv[1][32] ? 33'(-dv[1]) : 33'(dv[1]);
        3'd2: mul_a = dv[2][32] ? 33'(-dv[2]) : 33'(dv[2]);
        default: mul_a = '0;
      endcase
      mul_b = mul_a;
    end else if (state == ST_MUL && j < 3'd6) begin
      axis = 2'(j >> 1);
      if (!j[0]) begin
        mul_a   = dv[axis][32] ? 33'(-dv[axis]) : 33'(dv[axis]);
        mul_b   = 33'(f);
        mul_neg = dv[axis][32];
      end else begin
        mul_a   = dir_c[axis][31] ? 33'(-{dir_c[axis][31], dir_c[axis]})
                                  : 33'(dir_c[axis]);
        mul_b   = py[32] ? 33'(-py) : 33'(py);
        mul_neg = dir_c[axis][31] ^ py[32];
      end
    end
  end

  assign sq_go = (state == ST_SQ) && (j == 3'd3);

  ppw_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_go),
    .radicand (acc + prod),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign upper  = lower + LW'(sq_root);
  assign px_e   = (LW+1)'(px);
  assign hit    = (px_e >= $signed({1'b0, lower})) && (px_e < $signed({1'b0, upper}));
  assign diff   = px_e - $signed({1'b0, lower});
  assign div_go = (state == ST_ROOT) && sq_done && hit;

  ppw_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (diff[ppw_pkg::NUM_W-1:0]),
    .den   (sq_root),
    .done  (div_done),
    .quot  (div_q)
  );

  // term from the product of the previous multiply step
  assign jm      = j - 3'd1;
  assign shifted = jm[0] ? (prod >> 16) : (prod >> ppw_pkg::FRAC_W);
  assign term    = mneg ? -$signed(RW'(shifted)) : $signed(RW'(shifted));

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (res[a] > RW'(signed'(32'sh7fffffff))) begin
        sat[a] = 32'sh7fffffff;
      end else if (res[a] < -RW'(signed'(33'sh080000000))) begin
        sat[a] = 32'sh80000000;
      end else begin
        sat[a] = res[a][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    mneg <= mul_neg;
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      points_in_use <= ppw_pkg::PTS_W'(256);
      k             <= '0;
      j             <= '0;
    end else begin
      if (cfg_we) begin
        points_in_use <= cfg_data;
      end
      if (state == ST_FIN && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && in_data.operation == ppw_pkg::OP_MAP) begin
            px    <= 33'(in_data.glyph_x) + 33'(in_data.shift_x);
            py    <= 33'(in_data.glyph_y) + 33'(in_data.shift_y);
            lower <= '0;
            k     <= '0;
            off   <= 1'b1;
            for (int a = 0; a < 3; a++) res[a] <= '0;
            state <= (n_use < NW'(2)) ? ST_FIN : ST_FETCH;
          end
        end
        ST_FETCH: state <= ST_CAPT;
        ST_CAPT: begin
          for (int a = 0; a < 3; a++) begin
            p1[a] <= pos_c[a];
            p0[a] <= p1[a];
            dv[a] <= 33'(pos_c[a]) - 33'(p1[a]);
          end
          if (k == '0) begin
            k     <= AW'(1);
            state <= ST_FETCH;
          end else begin
            acc   <= '0;
            j     <= '0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (j != 3'd0) acc <= acc + prod;
          j <= j + 3'd1;
          if (j == 3'd3) state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sq_done) begin
            if (hit) begin
              off   <= 1'b0;
              state <= ST_DIV;
            end else if (NW'(k) == n_use - NW'(1)) begin
              state <= ST_FIN;
            end else begin
              lower <= upper;
              k     <= k + AW'(1);
              state <= ST_FETCH;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            f <= div_q;
            j <= '0;
            for (int a = 0; a < 3; a++) res[a] <= RW'(p0[a]);
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (j != 3'd0) res[2'(jm >> 1)] <= res[2'(jm >> 1)] + term;
          j <= j + 3'd1;
          if (j == 3'd6) state <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || !out_stall) begin
            out_data.out_x    <= off ? 32'sd0 : sat[0];
            out_data.out_y    <= off ? 32'sd0 : sat[1];
            out_data.out_z    <= off ? 32'sd0 : sat[2];
            out_data.off_path <= off;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) sq_done |-> state == ST_ROOT)
    else $error("root result outside the walk");
  assert property (@(posedge clk) disable iff (rst) div_done |-> state == ST_DIV)
    else $error("fraction result outside the divide step");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> (NW'(k) < n_use))
    else $error("walk past the last point");
  assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.operation == ppw_pkg::OP_LOAD) |=> state == ST_IDLE)
    else $error("load beat left the idle state");

endmodule
